// ===== rtl/tks_pkg.sv =====
// tks_pkg: shared widths, sizes and codes for the kahn topological sort core
// no dependencies
package tks_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 256;
  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int EDGE_W = $clog2(MAX_EDGES);
  localparam int FILL_W = EDGE_W + 1;
  localparam int CNT_W = EDGE_W + 1;
  localparam int ID_W = 7;
  localparam int QPTR_W = NODE_W + 1;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [ID_W-1:0] MAX_NODES_ID = ID_W'(MAX_NODES);

  typedef enum logic {
    ACT_ADD_EDGE = 1'b0,
    ACT_SORT     = 1'b1
  } action_t;

  typedef enum logic {
    REG_NODE_COUNT = 1'b0
  } reg_index_t;

endpackage

// ===== rtl/tks_ifs.sv =====
// tks_ifs: valid/ready channel interfaces for command beats and result beats
// depends on tks_pkg
interface tks_cmd_if;
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [tks_pkg::ID_W-1:0] from_node;
  logic [tks_pkg::ID_W-1:0] to_node;

  modport source (output valid, action, from_node, to_node, input ready);
  modport sink (input valid, action, from_node, to_node, output ready);
endinterface

interface tks_res_if;
  logic                   valid;
  logic                   ready;
  logic [tks_pkg::ID_W-1:0] node_id;
  logic                   last;
  logic                   incomplete;
  logic                   edges_dropped;

  modport source (output valid, node_id, last, incomplete, edges_dropped, input ready);
  modport sink (input valid, node_id, last, incomplete, edges_dropped, output ready);
endinterface

// ===== rtl/tks_apb_regs.sv =====
// tks_apb_regs: apb register port holding node_count, with clamped node total
// depends on tks_pkg
module tks_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tks_pkg::PADDR_W-1:0] paddr,
  input  logic [tks_pkg::PDATA_W-1:0] pwdata,
  output logic [tks_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [tks_pkg::ID_W-1:0]    node_total
);

  logic [tks_pkg::ID_W-1:0] node_count;
  logic                     sel_node_count;

  assign pready = 1'b1;
  assign sel_node_count = (paddr[2] == tks_pkg::REG_NODE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= tks_pkg::ID_W'(1);
    end else if (psel && penable && pwrite && sel_node_count) begin
      node_count <= pwdata[tks_pkg::ID_W-1:0];
    end
  end

  assign prdata = sel_node_count ?
                  {{(tks_pkg::PDATA_W-tks_pkg::ID_W){1'b0}}, node_count} : '0;

  assign node_total = (node_count > tks_pkg::MAX_NODES_ID) ? tks_pkg::MAX_NODES_ID
                                                          : node_count;

endmodule

// ===== rtl/topological_sort_kahn_core.sv =====
// topological_sort_kahn_core: edge store and kahn sort sequencer over block memories
// depends on tks_pkg, tks_ifs, tks_apb_regs
//
// usage:
//   cmd beats with action add-edge append from_node -> to_node to the
//   adjacency store; they give no result and run as one memory read, then
//   one write back. bad endpoints or a full store drop the edge and set
//   the drop flag.
//   a cmd beat with action sort runs kahn's algorithm: it seeds the queue,
//   then takes each popped node through S_POP, S_NODE and S_HEAD and each
//   edge through S_E_RD, S_E_DEG and S_E_UPD, bound by registered reads of
//   the count, list, edge and queue memories. one res beat per ordered node,
//   the final one with last set; if no node is ordered, one beat with node_id 0.
//   the result register lets the next cmd beat in while a result waits;
//   a stalled receiver holds the sequencer at its next emit.
//   after the sort the store and counts are cleared at once through
//   per-node valid bits, and the drop flag with them. node_count is kept.
//   reset (rst, synchronous) clears the store and sets node_count to 1.
module topological_sort_kahn_core (
  input  logic                        clk,
  input  logic                        rst,
  tks_cmd_if.sink                     cmd,
  tks_res_if.source                   res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tks_pkg::PADDR_W-1:0] paddr,
  input  logic [tks_pkg::PDATA_W-1:0] pwdata,
  output logic [tks_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int NW = tks_pkg::NODE_W;
  localparam int EW = tks_pkg::EDGE_W;
  localparam int IW = tks_pkg::ID_W;
  localparam int QW = tks_pkg::QPTR_W;
  localparam int CW = tks_pkg::CNT_W;
  localparam int FW = tks_pkg::FILL_W;
  localparam int NN = tks_pkg::MAX_NODES;
  localparam int NE = tks_pkg::MAX_EDGES;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD_WR, S_SEED, S_POP, S_NODE, S_HEAD, S_E_RD, S_E_DEG, S_E_UPD, S_FINISH
  } state_t;

  state_t        st;
  logic [IW-1:0] n_eff;

  tks_apb_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .node_total(n_eff)
  );

  logic [CW-1:0]   deg_mem [NN];
  logic [2*EW-1:0] list_mem [NN];
  logic [NW-1:0]   tgt_mem [NE];
  logic [EW-1:0]   nxt_mem [NE];
  logic [NW-1:0]   q_mem [NN];

  logic [CW-1:0]   deg_rd;
  logic [2*EW-1:0] list_rd;
  logic [NW-1:0]   tgt_rd;
  logic [EW-1:0]   nxt_rd;
  logic [NW-1:0]   q_rd;

  logic [NN-1:0] deg_valid;
  logic [NN-1:0] list_valid;
  logic [FW-1:0] fill;
  logic          drop;
  logic [NW-1:0] s_reg;
  logic [NW-1:0] t_reg;
  logic [EW-1:0] e_reg;
  logic [EW-1:0] tail_reg;
  logic [QW-1:0] qhead;
  logic [QW-1:0] qtail;
  logic [IW-1:0] seed_idx;
  logic [IW-1:0] emitted;
  logic [NW-1:0] pend;
  logic          have_pend;

  logic          cmd_acc;
  logic [IW-1:0] from_m1;
  logic [IW-1:0] to_m1;
  logic          bad_edge;
  logic          slot_free;
  logic          q_empty;
  logic          res_load;

  logic          list_re, deg_re, edge_re, q_re;
  logic [NW-1:0] list_ra, deg_ra;
  logic          deg_we, list_we, tgt_we, nxt_we, q_we;
  logic [NW-1:0] deg_wa, q_wa, q_wd;
  logic [CW-1:0] deg_wd;
  logic [CW-1:0] cnt_cur;
  logic          seed_push, upd_push, dec;
  logic [EW-1:0] new_e;
  logic [EW-1:0] new_head;

  assign cmd.ready = (st == S_IDLE);
  assign cmd_acc = cmd.valid && cmd.ready;
  assign from_m1 = cmd.from_node - IW'(1);
  assign to_m1 = cmd.to_node - IW'(1);
  assign bad_edge = (cmd.from_node == '0) || (cmd.from_node > n_eff) ||
                    (cmd.to_node == '0) || (cmd.to_node > n_eff) ||
                    (fill == FW'(NE));
  assign slot_free = !res.valid || res.ready;
  assign q_empty = (qhead == qtail);
  assign res_load = slot_free && (((st == S_NODE) && have_pend) || (st == S_FINISH));
  assign new_e = fill[EW-1:0];
  assign new_head = list_valid[s_reg] ? list_rd[2*EW-1:EW] : new_e;

  assign cnt_cur = deg_valid[t_reg] ? deg_rd : '0;
  assign dec = (cnt_cur != '0);
  assign seed_push = (st == S_SEED) && (seed_idx < n_eff) && !deg_valid[seed_idx[NW-1:0]];
  assign upd_push = (st == S_E_UPD) && dec && (cnt_cur == CW'(1)) &&
                    ({1'b0, t_reg} < n_eff) && (qtail < QW'(NN));

  always_comb begin
    list_re = 1'b0;
    list_ra = from_m1[NW-1:0];
    deg_re = 1'b0;
    deg_ra = to_m1[NW-1:0];
    edge_re = (st == S_E_RD);
    q_re = (st == S_POP) && !q_empty;
    deg_we = 1'b0;
    deg_wa = t_reg;
    deg_wd = cnt_cur + CW'(1);
    list_we = (st == S_ADD_WR);
    tgt_we = (st == S_ADD_WR);
    nxt_we = (st == S_ADD_WR) && list_valid[s_reg];
    q_we = seed_push || upd_push;
    q_wa = qtail[NW-1:0];
    q_wd = (st == S_SEED) ? seed_idx[NW-1:0] : t_reg;
    unique case (st)
      S_IDLE: begin
        list_re = cmd_acc && (cmd.action == tks_pkg::ACT_ADD_EDGE);
        deg_re = list_re;
      end
      S_ADD_WR: deg_we = 1'b1;
      S_NODE: begin
        list_re = !have_pend || slot_free;
        list_ra = q_rd;
      end
      S_E_DEG: begin
        deg_re = 1'b1;
        deg_ra = tgt_rd;
      end
      S_E_UPD: begin
        deg_we = dec;
        deg_wd = cnt_cur - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (deg_re) deg_rd <= deg_mem[deg_ra];
    if (list_re) list_rd <= list_mem[list_ra];
    if (edge_re) begin
      tgt_rd <= tgt_mem[e_reg];
      nxt_rd <= nxt_mem[e_reg];
    end
    if (q_re) q_rd <= q_mem[qhead[NW-1:0]];
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    if (list_we) list_mem[s_reg] <= {new_head, new_e};
    if (tgt_we) tgt_mem[new_e] <= t_reg;
    if (nxt_we) nxt_mem[list_rd[EW-1:0]] <= new_e;
    if (q_we) q_mem[q_wa] <= q_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      deg_valid <= '0;
      list_valid <= '0;
      fill <= '0;
      drop <= 1'b0;
      have_pend <= 1'b0;
      res.valid <= 1'b0;
      qhead <= '0;
      qtail <= '0;
      seed_idx <= '0;
      emitted <= '0;
    end else begin
      if (res.valid && res.ready && !res_load) res.valid <= 1'b0;
      if (q_we) qtail <= qtail + QW'(1);
      unique case (st)
        S_IDLE: begin
          if (cmd_acc) begin
            if (cmd.action == tks_pkg::ACT_SORT) begin
              qhead <= '0;
              qtail <= '0;
              seed_idx <= '0;
              emitted <= '0;
              have_pend <= 1'b0;
              st <= S_SEED;
            end else if (bad_edge) begin
              drop <= 1'b1;
            end else begin
              s_reg <= from_m1[NW-1:0];
              t_reg <= to_m1[NW-1:0];
              st <= S_ADD_WR;
            end
          end
        end
        S_ADD_WR: begin
          deg_valid[t_reg] <= 1'b1;
          list_valid[s_reg] <= 1'b1;
          fill <= fill + FW'(1);
          st <= S_IDLE;
        end
        S_SEED: begin
          if (seed_idx < n_eff) seed_idx <= seed_idx + IW'(1);
          else st <= S_POP;
        end
        S_POP: begin
          if (q_empty) begin
            st <= S_FINISH;
          end else begin
            qhead <= qhead + QW'(1);
            st <= S_NODE;
          end
        end
        S_NODE: begin
          if (!have_pend || slot_free) begin
            if (have_pend) begin
              res.valid <= 1'b1;
              res.node_id <= IW'(pend) + IW'(1);
              res.last <= 1'b0;
              res.incomplete <= 1'b0;
              res.edges_dropped <= 1'b0;
            end
            pend <= q_rd;
            have_pend <= 1'b1;
            emitted <= emitted + IW'(1);
            st <= S_HEAD;
          end
        end
        S_HEAD: begin
          if (list_valid[pend]) begin
            e_reg <= list_rd[2*EW-1:EW];
            tail_reg <= list_rd[EW-1:0];
            st <= S_E_RD;
          end else begin
            st <= S_POP;
          end
        end
        S_E_RD: st <= S_E_DEG;
        S_E_DEG: begin
          t_reg <= tgt_rd;
          st <= S_E_UPD;
        end
        S_E_UPD: begin
          if (e_reg == tail_reg) begin
            st <= S_POP;
          end else begin
            e_reg <= nxt_rd;
            st <= S_E_RD;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            res.valid <= 1'b1;
            res.last <= 1'b1;
            res.edges_dropped <= drop;
            if (have_pend) begin
              res.node_id <= IW'(pend) + IW'(1);
              res.incomplete <= (emitted < n_eff);
            end else begin
              res.node_id <= '0;
              res.incomplete <= (n_eff != '0);
            end
            deg_valid <= '0;
            list_valid <= '0;
            fill <= '0;
            drop <= 1'b0;
            have_pend <= 1'b0;
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/topological_sort_kahn_core_tb.sv =====
// topological_sort_kahn_core_tb: self-checking bench for the kahn topological sort core
// predicts every result beat from its own graph model and checks them in order
// depends on tks_pkg, tks_ifs and topological_sort_kahn_core
module topological_sort_kahn_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [tks_pkg::ID_W-1:0] node_id;
    logic                     last;
    logic                     incomplete;
    logic                     edges_dropped;
  } order_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tks_pkg::PADDR_W-1:0] paddr = '0;
  logic [tks_pkg::PDATA_W-1:0] pwdata = '0;
  logic [tks_pkg::PDATA_W-1:0] prdata;
  logic pready;

  tks_cmd_if cmd_ch();
  tks_res_if res_ch();

  topological_sort_kahn_core dut (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // graph model
  logic [6:0] node_count_q;
  logic [8:0] in_count[tks_pkg::MAX_NODES];
  int         out_edges[tks_pkg::MAX_NODES][$];
  int         stored_edges;
  logic       dropped_any;
  order_beat_t order_q[$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int hold_cnt = 0;
  bit hold_req = 0;
  bit stall_mode = 0;
  bit offering = 0;
  int items_sent = 0;

  function automatic int live_nodes();
    return (node_count_q > tks_pkg::MAX_NODES) ? tks_pkg::MAX_NODES : int'(node_count_q);
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < tks_pkg::MAX_NODES; i++) begin
      in_count[i] = '0;
      out_edges[i].delete();
    end
    stored_edges = 0;
    dropped_any = 1'b0;
  endfunction

  function automatic void predict_order(tks_pkg::action_t act, logic [6:0] src,
                                        logic [6:0] dst);
    int n;
    int ready_nodes[$];
    int v;
    int t;
    int emitted;
    order_beat_t beat;
    n = live_nodes();
    emitted = 0;
    if (act == tks_pkg::ACT_ADD_EDGE) begin
      if (src < 1 || src > n || dst < 1 || dst > n ||
          stored_edges >= tks_pkg::MAX_EDGES) begin
        dropped_any = 1'b1;
      end else begin
        out_edges[src-1] = {out_edges[src-1], int'(dst) - 1};
        in_count[dst-1]++;
        stored_edges++;
      end
      return;
    end
    for (int i = 0; i < n; i++)
      if (in_count[i] == 0) ready_nodes = {ready_nodes, i};
    while (ready_nodes.size() > 0) begin
      v = ready_nodes.pop_front();
      beat = '{node_id: tks_pkg::ID_W'(v + 1), last: 1'b0, incomplete: 1'b0,
               edges_dropped: 1'b0};
      order_q = {order_q, beat};
      emitted++;
      for (int k = 0; k < out_edges[v].size(); k++) begin
        t = out_edges[v][k];
        if (in_count[t] > 0) begin
          in_count[t]--;
          if (in_count[t] == 0 && t < n) ready_nodes = {ready_nodes, t};
        end
      end
    end
    if (emitted == 0) begin
      beat = '{node_id: '0, last: 1'b1, incomplete: (n > 0), edges_dropped: dropped_any};
      order_q = {order_q, beat};
    end else begin
      beat = order_q.pop_back();
      beat.last = 1'b1;
      beat.incomplete = (emitted < n);
      beat.edges_dropped = dropped_any;
      order_q = {order_q, beat};
    end
    clear_graph();
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("topological_sort_kahn_core regression: fail");
      $finish;
    end
  end

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    order_beat_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (order_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat node_id=%0d last=%0b", $time,
                   res_ch.node_id, res_ch.last);
        end else begin
          want = order_q.pop_front();
          if (res_ch.node_id !== want.node_id || res_ch.last !== want.last ||
              res_ch.incomplete !== want.incomplete ||
              res_ch.edges_dropped !== want.edges_dropped) begin
            errors++;
            $display("%0t: mismatch expected id=%0d last=%0b inc=%0b drop=%0b",
                     $time, want.node_id, want.last, want.incomplete, want.edges_dropped);
            $display("%0t:          actual id=%0d last=%0b inc=%0b drop=%0b",
                     $time, res_ch.node_id, res_ch.last, res_ch.incomplete,
                     res_ch.edges_dropped);
          end
        end
      end
      if (cycles % 64 == 0) stall_mode = ($urandom_range(0, 2) == 0);
      if (hold_cnt > 0) begin
        hold_cnt--;
        res_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
    end
  end

  task automatic send_cmd(tks_pkg::action_t act, logic [6:0] src, logic [6:0] dst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        if (offering) cmd_ch.valid <= 1'b0;
        offering = 0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    offering = 1;
    cmd_ch.action <= act;
    cmd_ch.from_node <= src;
    cmd_ch.to_node <= dst;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_order(act, src, dst);
    items_sent++;
  endtask

  task automatic wait_idle();
    if (offering) cmd_ch.valid <= 1'b0;
    offering = 0;
    while (order_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(logic [6:0] value);
    wait_idle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= tks_pkg::PADDR_W'(4 * tks_pkg::REG_NODE_COUNT);
    pwdata <= tks_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    node_count_q = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_edge(int src, int dst);
    send_cmd(tks_pkg::ACT_ADD_EDGE, 7'(src), 7'(dst));
  endtask

  task automatic run_sort();
    send_cmd(tks_pkg::ACT_SORT, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  task automatic test_defaults();
    run_sort();
    add_edge(1, 1);
    run_sort();
  endtask

  task automatic test_zero_nodes();
    write_node_count(7'd0);
    add_edge(1, 1);
    run_sort();
  endtask

  task automatic test_bad_edges();
    write_node_count(7'd4);
    add_edge(0, 1);
    add_edge(5, 1);
    add_edge(1, 127);
    add_edge(64, 2);
    add_edge(1, 2);
    add_edge(3, 2);
    add_edge(3, 2);
    run_sort();
  endtask

  task automatic test_cycles();
    write_node_count(7'd3);
    add_edge(1, 2);
    add_edge(2, 3);
    add_edge(3, 1);
    run_sort();
    write_node_count(7'd5);
    add_edge(1, 2);
    add_edge(3, 4);
    add_edge(4, 3);
    run_sort();
  endtask

  task automatic test_clamped_count();
    write_node_count(7'd127);
    add_edge(64, 1);
    add_edge(1, 64);
    add_edge(65, 1);
    run_sort();
    write_node_count(7'd64);
    add_edge(64, 1);
    run_sort();
  endtask

  task automatic test_lowered_count();
    write_node_count(7'd8);
    add_edge(1, 7);
    add_edge(7, 8);
    add_edge(2, 3);
    add_edge(5, 2);
    write_node_count(7'd4);
    run_sort();
  endtask

  task automatic test_full_store();
    write_node_count(7'd2);
    for (int i = 0; i <= tks_pkg::MAX_EDGES; i++) add_edge(1, 2);
    run_sort();
  endtask

  task automatic test_backpressure();
    write_node_count(7'd64);
    hold_req = 1;
    for (int i = 1; i < 12; i++) add_edge(i, i + 1);
    run_sort();
    for (int i = 0; i < 4; i++) add_edge($urandom_range(1, 64), $urandom_range(1, 64));
    run_sort();
    wait_idle();
  endtask

  task automatic test_random_graphs();
    int n;
    int edges;
    int r;
    int a;
    int b;
    while (items_sent < 340) begin
      r = $urandom_range(0, 9);
      n = (r < 7) ? $urandom_range(2, 8) : (r < 9) ? $urandom_range(9, 64) : 64;
      if ($urandom_range(0, 3) == 0) write_node_count(7'(n));
      else if (node_count_q != 7'(n)) write_node_count(7'(n));
      edges = $urandom_range(0, (n < 8) ? 12 : 40);
      for (int i = 0; i < edges; i++) begin
        r = $urandom_range(0, 19);
        a = $urandom_range(1, n);
        b = $urandom_range(1, n);
        if (r < 16) begin
          if (a > b) begin
            int tmp;
            tmp = a;
            a = b;
            b = tmp;
          end
          if (a == b) b = (b < n) ? b + 1 : b;
          if (a == b) a = (a > 1) ? a - 1 : a;
        end else if (r == 19) begin
          a = $urandom_range(0, 127);
          b = $urandom_range(0, 127);
        end
        add_edge(a, b);
      end
      run_sort();
    end
  endtask

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.action = tks_pkg::ACT_ADD_EDGE;
    cmd_ch.from_node = '0;
    cmd_ch.to_node = '0;
    res_ch.ready = 1'b0;
    node_count_q = 7'd1;
    clear_graph();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_zero_nodes();
    test_bad_edges();
    test_cycles();
    test_clamped_count();
    test_lowered_count();
    test_full_store();
    test_backpressure();
    test_random_graphs();
    wait_idle();
    if (errors == 0) begin
      $display("topological_sort_kahn_core regression: pass");
    end else begin
      $display("topological_sort_kahn_core regression: fail");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/tks_pkg.sv
rtl/tks_ifs.sv
rtl/tks_apb_regs.sv
rtl/topological_sort_kahn_core.sv
tb/sv/topological_sort_kahn_core_tb.sv
